/* rtl/flhc_pkg.sv */
// shared types and constants of the fan level hysteresis controller
package flhc_pkg;

	localparam int unsigned MAX_LEVELS  = 4;
	localparam int unsigned TABLE_SLOTS = 4;
	localparam int unsigned LEVEL_CAP   = (MAX_LEVELS < TABLE_SLOTS) ? MAX_LEVELS : TABLE_SLOTS;

	localparam int unsigned DATA_W = 64;
	localparam int unsigned ADDR_W = 6;

	localparam logic [3:0] FAIL_LIMIT = 4'd10;
	localparam logic [3:0] FAIL_SAT   = 4'd11;
	localparam logic [6:0] DELAY_SAT  = 7'd127;

	// register indexes, one register every eight bytes
	localparam logic [2:0] REG_LEVEL_COUNT    = 3'd0;
	localparam logic [2:0] REG_ON_THRESHOLDS  = 3'd1;
	localparam logic [2:0] REG_OFF_THRESHOLDS = 3'd2;
	localparam logic [2:0] REG_RPM_TABLE      = 3'd3;
	localparam logic [2:0] REG_DELAY_TICKS    = 3'd4;

	localparam logic [2:0] RST_LEVEL_COUNT = 3'd4;
	localparam logic [6:0] RST_DELAY_TICKS = 7'd20;

	typedef struct packed {
		logic [2:0]  level_count;
		logic [31:0] on_thresholds;
		logic [31:0] off_thresholds;
		logic [63:0] rpm_table;
		logic [6:0]  delay_ticks;
	} cfg_t;

	typedef struct packed {
		logic [15:0] rpm_setpoint;
		logic        rpm_valid;
		logic        shutdown_request;
		logic [1:0]  fan_level;
	} res_t;

endpackage

/* rtl/flhc_regs.sv */
// configuration register file behind the apb-style port
module flhc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [flhc_pkg::ADDR_W-1:0]   paddr,
	input  logic [flhc_pkg::DATA_W-1:0]   pwdata,
	output logic [flhc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output flhc_pkg::cfg_t                cfg
);

	flhc_pkg::cfg_t cfg_q;
	logic [2:0]     reg_idx;
	logic           wr_en;

	assign reg_idx = paddr[flhc_pkg::ADDR_W-1:3];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_count    <= flhc_pkg::RST_LEVEL_COUNT;
			cfg_q.on_thresholds  <= '0;
			cfg_q.off_thresholds <= '0;
			cfg_q.rpm_table      <= '0;
			cfg_q.delay_ticks    <= flhc_pkg::RST_DELAY_TICKS;
		end else if (wr_en) begin
			unique case (reg_idx)
				flhc_pkg::REG_LEVEL_COUNT:    cfg_q.level_count    <= pwdata[2:0];
				flhc_pkg::REG_ON_THRESHOLDS:  cfg_q.on_thresholds  <= pwdata[31:0];
				flhc_pkg::REG_OFF_THRESHOLDS: cfg_q.off_thresholds <= pwdata[31:0];
				flhc_pkg::REG_RPM_TABLE:      cfg_q.rpm_table      <= pwdata;
				flhc_pkg::REG_DELAY_TICKS:    cfg_q.delay_ticks    <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			flhc_pkg::REG_LEVEL_COUNT:    prdata = {61'd0, cfg_q.level_count};
			flhc_pkg::REG_ON_THRESHOLDS:  prdata = {32'd0, cfg_q.on_thresholds};
			flhc_pkg::REG_OFF_THRESHOLDS: prdata = {32'd0, cfg_q.off_thresholds};
			flhc_pkg::REG_RPM_TABLE:      prdata = cfg_q.rpm_table;
			flhc_pkg::REG_DELAY_TICKS:    prdata = {57'd0, cfg_q.delay_ticks};
			default:                      prdata = '0;
		endcase
	end

endmodule

/* rtl/flhc_core.sv */
// level state, delay counters and failure count with their next-state logic
module flhc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  flhc_pkg::cfg_t      cfg,
	input  logic                step,
	input  logic signed [9:0]   temperature,
	input  logic                chipset_on,
	input  logic                sensor_read_ok,
	output flhc_pkg::res_t      res
);

	logic [1:0] level_q;
	logic [6:0] up_q;
	logic [6:0] dn_q;
	logic [3:0] fail_q;

	logic [1:0]        level_d;
	logic [6:0]        up_d;
	logic [6:0]        dn_d;
	logic [3:0]        fail_d;
	logic [2:0]        n_lvl;
	logic [6:0]        dly;
	logic [7:0]        on_byte;
	logic [7:0]        off_byte;
	logic signed [9:0] on_thr;
	logic signed [9:0] off_thr;
	logic              up_cond;
	logic              dn_cond;
	logic [6:0]        up_inc;
	logic [6:0]        dn_inc;

	always_comb begin
		n_lvl = (cfg.level_count == 3'd0) ? 3'd1 : cfg.level_count;
		if (n_lvl > 3'(flhc_pkg::LEVEL_CAP))
			n_lvl = 3'(flhc_pkg::LEVEL_CAP);
		dly      = (cfg.delay_ticks == 7'd0) ? 7'd1 : cfg.delay_ticks;
		on_byte  = cfg.on_thresholds[level_q*8 +: 8];
		off_byte = cfg.off_thresholds[level_q*8 +: 8];
		on_thr   = {{2{on_byte[7]}}, on_byte};
		off_thr  = {{2{off_byte[7]}}, off_byte};
		// no step up once the level has reached the top configured level, one below the count
		up_cond  = (({1'b0, level_q} + 3'd1) < n_lvl) && (temperature >= on_thr);
		dn_cond  = (level_q != 2'd0) && (temperature <= off_thr);
		up_inc   = (up_q < flhc_pkg::DELAY_SAT) ? up_q + 7'd1 : up_q;
		dn_inc   = (dn_q < flhc_pkg::DELAY_SAT) ? dn_q + 7'd1 : dn_q;

		level_d = level_q;
		up_d    = up_q;
		dn_d    = dn_q;
		fail_d  = fail_q;
		res.shutdown_request = 1'b0;

		if (chipset_on) begin
			if (!sensor_read_ok) begin
				if (fail_q < flhc_pkg::FAIL_SAT)
					fail_d = fail_q + 4'd1;
				res.shutdown_request = (fail_d > flhc_pkg::FAIL_LIMIT);
			end
			priority if (up_cond) begin
				dn_d = '0;
				if (up_inc >= dly) begin
					level_d = level_q + 2'd1;
					up_d    = '0;
				end else begin
					up_d = up_inc;
				end
			end else if (dn_cond) begin
				up_d = '0;
				if (dn_inc >= dly) begin
					level_d = level_q - 2'd1;
					dn_d    = '0;
				end else begin
					dn_d = dn_inc;
				end
			end else begin
				up_d = '0;
				dn_d = '0;
			end
		end else begin
			fail_d = '0;
		end

		res.rpm_valid    = chipset_on;
		res.rpm_setpoint = chipset_on ? cfg.rpm_table[level_d*16 +: 16] : 16'd0;
		res.fan_level    = level_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			up_q    <= '0;
			dn_q    <= '0;
			fail_q  <= '0;
		end else if (step) begin
			level_q <= level_d;
			up_q    <= up_d;
			dn_q    <= dn_d;
			fail_q  <= fail_d;
		end
	end

endmodule

/* rtl/fan_level_hysteresis_controller_unit.sv */
// fan level hysteresis controller top level: input register, core and result register
// Each thermal tick is one transaction in and one transaction out. A tick is taken into
// the input register, its level update runs through the core logic and lands in the
// result register, so a new tick is accepted every cycle while results are taken; the
// result is offered by the result register once the tick has moved on from the input
// register. The fan level steps up or down one level after delay_ticks consecutive
// qualifying ticks, the rpm setpoint comes from the new level's entry of rpm_table while
// the chipset is on, and a shutdown is requested on a failing read once more than ten
// failures have been counted since the chipset last was off. Registers sit at byte
// offsets 8*i on a 64-bit apb-style port (level_count, on_thresholds, off_thresholds,
// rpm_table, delay_ticks) and are to be written while no tick is in flight.
module fan_level_hysteresis_controller_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [9:0]             temperature,
	input  logic                          chipset_on,
	input  logic                          sensor_read_ok,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [15:0]                   rpm_setpoint,
	output logic                          rpm_valid,
	output logic                          shutdown_request,
	output logic [1:0]                    fan_level,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [flhc_pkg::ADDR_W-1:0]   paddr,
	input  logic [flhc_pkg::DATA_W-1:0]   pwdata,
	output logic [flhc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	flhc_pkg::cfg_t    cfg;
	flhc_pkg::res_t    res;
	flhc_pkg::res_t    res_q;
	logic              valid_s1;
	logic signed [9:0] temp_s1;
	logic              chip_s1;
	logic              ok_s1;
	logic              out_valid_q;
	logic              advance;
	logic              take_in;

	// the tick in the input register moves on when the result slot is free or draining
	assign advance  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign take_in  = in_valid & ~in_stall;

	flhc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	flhc_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.step           (advance),
		.temperature    (temp_s1),
		.chipset_on     (chip_s1),
		.sensor_read_ok (ok_s1),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_in)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (~out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			temp_s1 <= temperature;
			chip_s1 <= chipset_on;
			ok_s1   <= sensor_read_ok;
		end
		if (advance)
			res_q <= res;
	end

	assign out_valid        = out_valid_q;
	assign rpm_setpoint     = res_q.rpm_setpoint;
	assign rpm_valid        = res_q.rpm_valid;
	assign shutdown_request = res_q.shutdown_request;
	assign fan_level        = res_q.fan_level;

endmodule

/* test/tb_fan_level_hysteresis_controller_unit.sv */
// testbench of the fan level hysteresis controller: directed table, then random thermal tick runs
`timescale 1ns / 1ps
module tb_fan_level_hysteresis_controller_unit;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [2:0]        reg_idx;
		logic [63:0]       value;
		logic signed [9:0] temp;
		logic              chip;
		logic              read_ok;
		logic              typed;
		flhc_pkg::res_t    want;
	} row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic signed [9:0]             temperature;
	logic                          chipset_on;
	logic                          sensor_read_ok;
	logic                          out_valid;
	logic                          out_stall;
	logic [15:0]                   rpm_setpoint;
	logic                          rpm_valid;
	logic                          shutdown_request;
	logic [1:0]                    fan_level;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [flhc_pkg::ADDR_W-1:0]   paddr;
	logic [flhc_pkg::DATA_W-1:0]   pwdata;
	logic [flhc_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	// shadow of the block's registers and thermal state
	flhc_pkg::cfg_t cfg_q;
	logic [1:0]     lvl_q;
	logic [6:0]     up_run;
	logic [6:0]     down_run;
	logic [3:0]     fail_run;

	flhc_pkg::res_t pending_results[$];
	bit   idle_on = 1'b1;
	int   error_total = 0;
	int   ticks_sent = 0;
	int   results_seen = 0;
	int   shutdowns_seen = 0;
	int   config_writes = 0;

	fan_level_hysteresis_controller_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int levels_used();
		int n;
		n = cfg_q.level_count;
		if (n == 0)
			n = 1;
		if (n > int'(flhc_pkg::LEVEL_CAP))
			n = int'(flhc_pkg::LEVEL_CAP);
		return n;
	endfunction

	function automatic int on_temp(logic [1:0] l);
		logic signed [7:0] b;
		b = cfg_q.on_thresholds[8*l +: 8];
		return int'(b);
	endfunction

	function automatic int off_temp(logic [1:0] l);
		logic signed [7:0] b;
		b = cfg_q.off_thresholds[8*l +: 8];
		return int'(b);
	endfunction

	// advances the shadow state by one tick and returns the result it should produce
	function automatic flhc_pkg::res_t next_fan_result(logic signed [9:0] t, logic chip,
			logic read_ok);
		flhc_pkg::res_t r;
		logic [6:0]     need;
		r = '0;
		need = (cfg_q.delay_ticks == 7'd0) ? 7'd1 : cfg_q.delay_ticks;
		if (chip) begin
			if (!read_ok) begin
				if (fail_run < flhc_pkg::FAIL_SAT)
					fail_run++;
				r.shutdown_request = (fail_run > flhc_pkg::FAIL_LIMIT);
			end
			if (int'(lvl_q) + 1 < levels_used() && int'(t) >= on_temp(lvl_q)) begin
				if (up_run < flhc_pkg::DELAY_SAT)
					up_run++;
				if (up_run >= need) begin
					lvl_q++;
					up_run = '0;
				end
				down_run = '0;
			end else if (lvl_q != 2'd0 && int'(t) <= off_temp(lvl_q)) begin
				if (down_run < flhc_pkg::DELAY_SAT)
					down_run++;
				if (down_run >= need) begin
					lvl_q--;
					down_run = '0;
				end
				up_run = '0;
			end else begin
				up_run = '0;
				down_run = '0;
			end
			r.rpm_setpoint = cfg_q.rpm_table[16*lvl_q +: 16];
			r.rpm_valid = 1'b1;
		end else begin
			fail_run = '0;
		end
		r.fan_level = lvl_q;
		return r;
	endfunction

	// mostly back to back, sometimes a short gap, rarely a long one
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic row_t tick_row(int t, logic chip, logic read_ok);
		row_t r;
		r = '{ROW_TICK, 3'd0, 64'd0, t[9:0], chip, read_ok, 1'b0, '0};
		return r;
	endfunction

	function automatic row_t cfg_row(logic [2:0] idx, logic [63:0] value);
		row_t r;
		r = '{ROW_CFG, idx, value, 10'sd0, 1'b0, 1'b0, 1'b0, '0};
		return r;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_total++;
		end
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			flhc_pkg::REG_LEVEL_COUNT:    cfg_q.level_count = value[2:0];
			flhc_pkg::REG_ON_THRESHOLDS:  cfg_q.on_thresholds = value[31:0];
			flhc_pkg::REG_OFF_THRESHOLDS: cfg_q.off_thresholds = value[31:0];
			flhc_pkg::REG_RPM_TABLE:      cfg_q.rpm_table = value;
			flhc_pkg::REG_DELAY_TICKS:    cfg_q.delay_ticks = value[6:0];
			default: ;
		endcase
		config_writes++;
	endtask

	// wait until every tick has come back, then idle
	task automatic settle();
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic drive_tick(logic signed [9:0] t, logic chip, logic read_ok, logic typed,
			flhc_pkg::res_t want);
		int             gap;
		flhc_pkg::res_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		temperature = t;
		chipset_on = chip;
		sensor_read_ok = read_ok;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		predicted = next_fan_result(t, chip, read_ok);
		pending_results.push_back(typed ? want : predicted);
		ticks_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// receiver stall pattern
	initial begin
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_stall = 1'b1;
				hold--;
			end else begin
				out_stall = 1'b0;
				hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		flhc_pkg::res_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result transaction with no tick pending, fan_level %0d", fan_level);
				error_total++;
			end else begin
				want = pending_results.pop_front();
				if (want.shutdown_request)
					shutdowns_seen++;
				check_field("rpm_setpoint", want.rpm_setpoint, rpm_setpoint);
				check_field("rpm_valid", 16'(want.rpm_valid), 16'(rpm_valid));
				check_field("shutdown_request", 16'(want.shutdown_request),
					16'(shutdown_request));
				check_field("fan_level", 16'(want.fan_level), 16'(fan_level));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("fan_level_hysteresis_controller_unit verification failed");
		$finish;
	end

	initial begin
		row_t              plan[$];
		row_t              r;
		int                directed_ticks;
		int                random_ticks;
		int                phase;
		int                phase_len;
		int                need;
		int                span;
		int                mode;
		int                run_len;
		int                base;
		int                tv;
		int                k;
		logic [31:0]       on_w;
		logic [31:0]       off_w;
		logic signed [9:0] t;
		logic              chip;
		logic              read_ok;

		arst_n = 1'b0;
		in_valid = 1'b0;
		temperature = '0;
		chipset_on = 1'b0;
		sensor_read_ok = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_q = '{flhc_pkg::RST_LEVEL_COUNT, 32'd0, 32'd0, 64'd0, flhc_pkg::RST_DELAY_TICKS};
		lvl_q = '0;
		up_run = '0;
		down_run = '0;
		fail_run = '0;

		// reset registers: one step toward level 1, all setpoints zero
		r = tick_row(0, 1'b1, 1'b1);
		r.typed = 1'b1;
		r.want = '{rpm_setpoint: 16'd0, rpm_valid: 1'b1, shutdown_request: 1'b0,
			fan_level: 2'd0};
		plan.push_back(r);
		// chipset off gives an all-zero result at the held level
		r = tick_row(-512, 1'b0, 1'b0);
		r.typed = 1'b1;
		r.want = '{rpm_setpoint: 16'd0, rpm_valid: 1'b0, shutdown_request: 1'b0,
			fan_level: 2'd0};
		plan.push_back(r);
		plan.push_back(cfg_row(flhc_pkg::REG_RPM_TABLE, 64'h0001_8000_7FFF_FFFF));
		plan.push_back(cfg_row(flhc_pkg::REG_ON_THRESHOLDS, 64'h55_00_80_7F));
		plan.push_back(cfg_row(flhc_pkg::REG_OFF_THRESHOLDS, 64'h7F_00_80_81));
		plan.push_back(cfg_row(flhc_pkg::REG_DELAY_TICKS, 64'd0));
		plan.push_back(cfg_row(flhc_pkg::REG_LEVEL_COUNT, 64'd7));
		// zero delay and an oversized level count; failed reads still steer the level
		plan.push_back(tick_row(511, 1'b1, 1'b0));
		plan.push_back(tick_row(-128, 1'b1, 1'b0));
		plan.push_back(tick_row(0, 1'b1, 1'b0));
		plan.push_back(tick_row(511, 1'b1, 1'b0));
		plan.push_back(tick_row(127, 1'b1, 1'b0));
		// a good read keeps the failure count
		plan.push_back(tick_row(100, 1'b1, 1'b1));
		plan.push_back(tick_row(128, 1'b1, 1'b0));
		plan.push_back(tick_row(-1, 1'b1, 1'b0));
		plan.push_back(tick_row(-1, 1'b1, 1'b0));
		plan.push_back(tick_row(-129, 1'b1, 1'b0));
		plan.push_back(tick_row(126, 1'b1, 1'b0));
		// eleventh failure requests shutdown, and the count saturates
		plan.push_back(tick_row(127, 1'b1, 1'b0));
		plan.push_back(tick_row(-512, 1'b1, 1'b0));
		plan.push_back(tick_row(0, 1'b0, 1'b1));
		plan.push_back(tick_row(511, 1'b1, 1'b0));
		plan.push_back(tick_row(511, 1'b1, 1'b1));
		// level left above a lowered count only steps down
		plan.push_back(cfg_row(flhc_pkg::REG_LEVEL_COUNT, 64'd0));
		plan.push_back(tick_row(511, 1'b1, 1'b1));
		plan.push_back(tick_row(-5, 1'b1, 1'b1));
		plan.push_back(cfg_row(flhc_pkg::REG_DELAY_TICKS, 64'd2));
		plan.push_back(cfg_row(flhc_pkg::REG_LEVEL_COUNT, 64'd4));
		plan.push_back(tick_row(0, 1'b1, 1'b1));
		plan.push_back(tick_row(-300, 1'b1, 1'b1));
		plan.push_back(tick_row(-300, 1'b1, 1'b1));
		plan.push_back(tick_row(300, 1'b1, 1'b1));

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				settle();
				write_reg(plan[i].reg_idx, plan[i].value);
			end else begin
				drive_tick(plan[i].temp, plan[i].chip, plan[i].read_ok, plan[i].typed,
					plan[i].want);
			end
		end
		directed_ticks = ticks_sent;

		random_ticks = 0;
		phase = 0;
		while (random_ticks < 1050) begin
			settle();
			idle_on = (phase % 4 != 3);
			case (phase % 5)
				0: write_reg(flhc_pkg::REG_LEVEL_COUNT, 64'd4);
				1: write_reg(flhc_pkg::REG_LEVEL_COUNT, 64'd1);
				default: write_reg(flhc_pkg::REG_LEVEL_COUNT, 64'($urandom_range(0, 7)));
			endcase
			case (phase % 6)
				0: need = 0;
				1: need = 1;
				2: need = 127;
				3: need = $urandom_range(2, 4);
				default: need = $urandom_range(1, 12);
			endcase
			if (phase % 2 == 1) begin
				on_w = $urandom;
				off_w = $urandom;
			end else begin
				// rising thresholds with a hysteresis band under each one
				base = $urandom_range(0, 100) - 60;
				for (k = 0; k < 4; k++) begin
					tv = base + 20 * k + $urandom_range(0, 10);
					on_w[8*k +: 8] = tv[7:0];
					tv = tv - $urandom_range(0, 15);
					off_w[8*k +: 8] = tv[7:0];
				end
			end
			write_reg(flhc_pkg::REG_ON_THRESHOLDS, 64'(on_w));
			write_reg(flhc_pkg::REG_OFF_THRESHOLDS, 64'(off_w));
			write_reg(flhc_pkg::REG_RPM_TABLE, {$urandom, $urandom});
			write_reg(flhc_pkg::REG_DELAY_TICKS, 64'(need));
			span = (need == 0) ? 1 : need;
			phase_len = 100 + 2 * span;

			k = 0;
			while (k < phase_len) begin
				mode = $urandom_range(0, 9);
				case (mode)
					0, 1, 2, 3, 4, 5, 6: run_len = $urandom_range(1, span + 2);
					7: run_len = $urandom_range(1, 6);
					8: run_len = $urandom_range(6, 14);
					default: run_len = $urandom_range(1, 3);
				endcase
				repeat (run_len) begin
					chip = 1'b1;
					read_ok = ($urandom_range(0, 19) != 0);
					if (mode <= 3) begin
						tv = on_temp(lvl_q) + $urandom_range(0, 30);
						if ($urandom_range(0, 11) == 0)
							tv = on_temp(lvl_q) - 1;
					end else if (mode <= 6) begin
						tv = off_temp(lvl_q) - $urandom_range(0, 30);
					end else if (mode == 8) begin
						// burst of failed reads near the thresholds
						read_ok = 1'b0;
						tv = on_temp(lvl_q) - 15 + $urandom_range(0, 30);
					end else begin
						tv = $urandom_range(0, 1023);
						chip = (mode == 7);
					end
					t = tv[9:0];
					drive_tick(t, chip, read_ok, 1'b0, '0);
					k++;
				end
				if ($urandom_range(0, 39) == 0)
					settle();
			end
			random_ticks += k;
			phase++;
		end

		settle();
		repeat (8) @(negedge clk);
		$display("covered %0d thermal ticks (%0d directed, %0d random in %0d phases)",
			ticks_sent, directed_ticks, random_ticks, phase);
		$display("%0d register writes, %0d results checked, %0d shutdown requests",
			config_writes, results_seen, shutdowns_seen);
		if (error_total == 0 && pending_results.size() == 0) begin
			$display("fan_level_hysteresis_controller_unit verification clean");
		end else begin
			$display("fan_level_hysteresis_controller_unit verification failed");
		end
		$finish;
	end

endmodule
